// ===== src/i2a_pkg.sv =====
package i2a_pkg;

    localparam int VALUE_W    = 64;
    localparam int POS_W      = 8;
    localparam int CHAR_W     = 8;
    localparam int NUM_BCD    = 20;              // 2^64 fits in 20 decimal digits
    localparam int BCD_W      = 4 * NUM_BCD;
    localparam int BITS_PER_STAGE = 8;
    localparam int NUM_DABBLE = VALUE_W / BITS_PER_STAGE;
    localparam int CNT_W      = 5;               // holds 1..20
    localparam int MAX_DIGITS_DEF = 19;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;

    // Eight shift-add-3 steps, most significant input bit first.
    function automatic logic [BCD_W-1:0] dabble8(input logic [BCD_W-1:0] b,
                                                 input logic [BITS_PER_STAGE-1:0] bits);
        logic [BCD_W-1:0] t;
        t = b;
        for (int s = 0; s < BITS_PER_STAGE; s++) begin
            for (int d = 0; d < NUM_BCD; d++) begin
                if (t[d*4 +: 4] >= 4'd5) begin
                    t[d*4 +: 4] = t[d*4 +: 4] + 4'd3;
                end
            end
            t = {t[BCD_W-2:0], bits[BITS_PER_STAGE-1-s]};
        end
        return t;
    endfunction

endpackage

// ===== src/int64_to_decimal_ascii_unit.sv =====
// Channel | Ports          | Payload
// --------+----------------+-------------------------------------------------
// input   | s_tvalid/ready | s_tdata: value[63:0], start_pos[71:64]
// output  | m_tvalid/ready | m_tdata: position[7:0], character[15:8]; m_tlast
//
// Pipeline: 10 register stages (magnitude, 8 double-dabble stages of 8 bits
// each, digit count) before the first character. One character per cycle
// leaves the output register while m_tready is high, so an item holds the
// output for its sign, digits and terminator; the serializer sets the rate.
// Reset (aresetn low, synchronous) clears all valid bits.
// Stalls on m_tready ripple back through the stage valids; nothing is lost.
module int64_to_decimal_ascii_unit #(
    parameter int MAX_DIGITS = i2a_pkg::MAX_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // value[63:0], start_pos[71:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // position[7:0], character[15:8]
    output logic        m_tlast
);
    import i2a_pkg::*;

    localparam int NS = NUM_DABBLE + 1;   // stage 0 = magnitude

    // pipeline stage registers
    logic [NS-1:0]      v_reg;
    logic [VALUE_W-1:0] mag_reg [NS];
    logic [BCD_W-1:0]   bcd_reg [NS];
    logic               neg_reg [NS];
    logic [POS_W-1:0]   pos_reg [NS];
    logic [NS:0]        rdy;

    // digit count stage
    logic             cv_reg;
    logic [BCD_W-1:0] cbcd_reg;
    logic             cneg_reg;
    logic [POS_W-1:0] cpos_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // output serializer
    logic             ov_reg;
    logic             sgn_reg;
    logic             dig_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [POS_W-1:0] opos_reg;
    logic [BCD_W-1:0] obcd_reg;
    logic [CHAR_W-1:0] ch;
    logic             is_last;
    logic             ld_ok;

    assign is_last  = !sgn_reg && !dig_reg;
    assign ld_ok    = !ov_reg || (m_tready && is_last);
    assign s_tready = rdy[0];

    always_comb begin
        rdy[NS] = !cv_reg || ld_ok;
        for (int i = 0; i < NS; i++) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    // stage 0: magnitude as unsigned, bcd cleared
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (rdy[0]) begin
            v_reg[0] <= s_tvalid;
        end
        if (rdy[0] && s_tvalid) begin
            neg_reg[0] <= s_tdata[VALUE_W-1];
            mag_reg[0] <= s_tdata[VALUE_W-1] ? (~s_tdata[VALUE_W-1:0] + 64'd1)
                                             : s_tdata[VALUE_W-1:0];
            pos_reg[0] <= s_tdata[VALUE_W +: POS_W];
            bcd_reg[0] <= '0;
        end
    end

    // stages 1..8: 8 binary bits into the BCD word each
    for (genvar g = 1; g < NS; g++) begin : g_dabble
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (rdy[g]) begin
                v_reg[g] <= v_reg[g-1];
            end
            if (rdy[g] && v_reg[g-1]) begin
                bcd_reg[g] <= dabble8(bcd_reg[g-1],
                                      mag_reg[g-1][VALUE_W-1 -: BITS_PER_STAGE]);
                mag_reg[g] <= {mag_reg[g-1][VALUE_W-BITS_PER_STAGE-1:0],
                               {BITS_PER_STAGE{1'b0}}};
                neg_reg[g] <= neg_reg[g-1];
                pos_reg[g] <= pos_reg[g-1];
            end
        end
    end

    // significant digit count, at least one, capped at MAX_DIGITS
    always_comb begin
        cnt_next = CNT_W'(1);
        for (int d = 1; d < NUM_BCD; d++) begin
            if (bcd_reg[NS-1][d*4 +: 4] != 4'd0) begin
                cnt_next = CNT_W'(d + 1);
            end
        end
        if (cnt_next > CNT_W'(MAX_DIGITS)) begin
            cnt_next = CNT_W'(MAX_DIGITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg <= 1'b0;
        end else if (rdy[NS]) begin
            cv_reg <= v_reg[NS-1];
        end
        if (rdy[NS] && v_reg[NS-1]) begin
            cbcd_reg <= bcd_reg[NS-1];
            cneg_reg <= neg_reg[NS-1];
            cpos_reg <= pos_reg[NS-1];
            cnt_reg  <= cnt_next;
        end
    end

    // serializer: sign if negative, digits high to low, then terminator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (ld_ok) begin
            ov_reg <= cv_reg;
        end
        if (ld_ok && cv_reg) begin
            sgn_reg  <= cneg_reg;
            dig_reg  <= 1'b1;
            idx_reg  <= cnt_reg - CNT_W'(1);
            opos_reg <= cpos_reg;
            obcd_reg <= cbcd_reg;
        end else if (ov_reg && m_tready) begin
            opos_reg <= opos_reg + POS_W'(1);
            if (sgn_reg) begin
                sgn_reg <= 1'b0;
            end else if (dig_reg) begin
                if (idx_reg == '0) begin
                    dig_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg - CNT_W'(1);
                end
            end
        end
    end

    always_comb begin
        if (sgn_reg) begin
            ch = CHAR_MINUS;
        end else if (dig_reg) begin
            ch = CHAR_ZERO + {4'd0, obcd_reg[idx_reg*4 +: 4]};
        end else begin
            ch = CHAR_NUL;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {ch, opos_reg};
    assign m_tlast  = is_last;

endmodule

// ===== tb/sv/i2a_checker.sv =====
module i2a_checker #(
    parameter int MAX_DIGITS = i2a_pkg::MAX_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    output int          errors,
    output int          pending
);
    import i2a_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [CHAR_W-1:0] character;
        logic              last;
    } char_t;

    char_t text_q[$];

    // Expand one input item into its character sequence.
    task automatic convert_to_text(input logic [63:0] value, input logic [7:0] start);
        logic [63:0] mag;
        logic [3:0]  dig[MAX_DIGITS];
        int          nd;
        logic [7:0]  pos;
        char_t       c;
        mag = value[63] ? (~value + 64'd1) : value;
        nd = 0;
        pos = start;
        do begin
            dig[nd] = 4'(mag % 64'd10);
            mag = mag / 64'd10;
            nd++;
        end while (mag != 0 && nd < MAX_DIGITS);
        if (value[63]) begin
            c = '{pos, CHAR_MINUS, 1'b0};
            text_q.push_back(c);
            pos++;
        end
        for (int i = nd - 1; i >= 0; i--) begin
            c = '{pos, CHAR_ZERO + 8'(dig[i]), 1'b0};
            text_q.push_back(c);
            pos++;
        end
        c = '{pos, CHAR_NUL, 1'b1};
        text_q.push_back(c);
    endtask

    initial errors = 0;

    always @(posedge aclk) begin
        char_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (text_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected char: pos %0d chr %0d last %0b",
                                 m_tdata[7:0], m_tdata[15:8], m_tlast);
                end else begin
                    e = text_q.pop_front();
                    if (e.position !== m_tdata[7:0] || e.character !== m_tdata[15:8] ||
                        e.last !== m_tlast) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp pos %0d chr %0d last %0b, got %0d %0d %0b",
                                     e.position, e.character, e.last,
                                     m_tdata[7:0], m_tdata[15:8], m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
                convert_to_text(s_tdata[63:0], s_tdata[71:64]);
        end
        pending = text_q.size();
    end
endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    int          errors;
    int          pending;
    bit          long_hold = 0;

    always #5 aclk = ~aclk;

    int64_to_decimal_ascii_unit dut (.*);

    i2a_checker chk (.*);

    // Receiver: random stalls; one long hold-off while the sender keeps going.
    initial begin
        int w;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_hold) begin
                m_tready <= 0;
                repeat (300) @(posedge aclk);
                long_hold = 0;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if ($urandom_range(0, 1)) w = 0;
            if (w > 0) begin
                m_tready <= 0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
        end
    end

    task automatic send_item(input logic [63:0] v, input logic [7:0] p, input bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 17) : 0;
        if (gaps && $urandom_range(0, 1)) w = 0;
        if (w > 0) begin
            s_tvalid <= 0;
            repeat (w) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {p, v};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        int k;
        v = {$urandom, $urandom};
        k = $urandom_range(0, 5);
        unique case (k)
            0: v = v >> $urandom_range(0, 63);                   // short magnitudes
            1: v = -(v >> $urandom_range(0, 63));                // short negatives
            2: v = 64'(64'd10 ** $urandom_range(0, 18)) + $signed($urandom_range(0, 2)) - 1;
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        logic [63:0] dir[$];
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        dir = '{64'd0, 64'd1, 64'd9, 64'd10, -64'sd1, -64'sd10, 64'h7FFF_FFFF_FFFF_FFFF,
                64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001, 64'd999999999,
                64'd1000000000, 64'd1000000000000000000, -64'sd1000000000000000000,
                64'd999999999999999999, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
                64'hAAAA_AAAA_AAAA_AAAA};
        foreach (dir[i])
            send_item(dir[i], (i % 3 == 0) ? 8'd0 : (i % 3 == 1) ? 8'd235 : 8'd255, 0);
        // Sender waits for every expected character.
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        long_hold = 1;
        for (int n = 0; n < 270; n++)
            send_item(rand_value(), 8'($urandom_range(0, 255)), n > 40);
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (errors == 0)
            $display("int64_to_decimal_ascii_unit test passed");
        else
            $display("int64_to_decimal_ascii_unit test failed");
        $finish;
    end

    initial begin
        #10000000;
        $display("int64_to_decimal_ascii_unit test failed");
        $finish;
    end
endmodule

// ===== files.f =====
src/i2a_pkg.sv
src/int64_to_decimal_ascii_unit.sv
tb/sv/i2a_checker.sv
tb/sv/testbench.sv
